@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL modules (included by lmlt_step).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ rtl/lmlt_pkg.sv @@
// Types and constants for the LCD mode and line timing block.
package lmlt_pkg;

    localparam int ELAPSED_W  = 6;
    localparam int LINE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    localparam int OAM_END  = 81;
    localparam int DRAW_END = 253;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } lcd_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISPLAY_ENABLE   = 3'd0,
        REG_LINE_COMPARE     = 3'd1,
        REG_HBLANK_IRQ_EN    = 3'd2,
        REG_VBLANK_IRQ_EN    = 3'd3,
        REG_OAM_IRQ_EN       = 3'd4,
        REG_COINCIDENCE_IRQ  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic              display_enable;
        logic [LINE_W-1:0] line_compare_value;
        logic              hblank_irq_enable;
        logic              vblank_stat_irq_enable;
        logic              oam_irq_enable;
        logic              coincidence_irq_enable;
    } cfg_t;

    typedef struct packed {
        lcd_mode_t         lcd_mode;
        logic [LINE_W-1:0] current_line;
        logic              coincidence_flag;
        logic              stat_irq_request;
        logic              vblank_irq_request;
        logic              render_line_pulse;
        logic [LINE_W-1:0] render_line_number;
    } result_t;

endpackage

@@ rtl/lmlt_cfg_regs.sv @@
// Configuration register file of the LCD mode and line timing block.
module lmlt_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lmlt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmlt_pkg::CFG_DATA_W-1:0] cfg_data,
    output lmlt_pkg::cfg_t                 cfg
);
    import lmlt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_DISPLAY_ENABLE:  cfg_next.display_enable         = cfg_data[0];
                REG_LINE_COMPARE:    cfg_next.line_compare_value     = cfg_data[LINE_W-1:0];
                REG_HBLANK_IRQ_EN:   cfg_next.hblank_irq_enable      = cfg_data[0];
                REG_VBLANK_IRQ_EN:   cfg_next.vblank_stat_irq_enable = cfg_data[0];
                REG_OAM_IRQ_EN:      cfg_next.oam_irq_enable         = cfg_data[0];
                REG_COINCIDENCE_IRQ: cfg_next.coincidence_irq_enable = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{display_enable: 1'b1, default: '0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/lmlt_step.sv @@
// Line timing state and the per-request mode, interrupt and render update.
`include "assert_macros.svh"

module lmlt_step #(
    parameter int LINE_CYCLES   = 456,
    parameter int VISIBLE_LINES = 144,
    parameter int LAST_LINE     = 154
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lmlt_pkg::cfg_t                 cfg,
    input  logic                           advance,
    input  logic [lmlt_pkg::ELAPSED_W-1:0] elapsed_cycles,
    output lmlt_pkg::result_t              result
);
    import lmlt_pkg::*;

    localparam int CNT_W = $clog2(LINE_CYCLES + 64);
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

    logic [CNT_W-1:0]  lcc_reg, lcc_next;
    logic [LINE_W-1:0] line_reg, line_next;
    lcd_mode_t         mode_reg, mode_next;
    lcd_mode_t         prev_mode_reg, prev_mode_next;
    logic              line_done_reg, line_done_next;
    logic              frame_done_reg, frame_done_next;
    logic              coin_reg, coin_next;

    logic [CNT_W-1:0]  cnt;
    logic [CMP_W-1:0]  cnt_ext;
    logic [LINE_W-1:0] line_adv;
    logic              vblank_line;
    logic              stat;
    logic              vbl;
    logic              render;
    logic [LINE_W-1:0] render_num;

    assign vblank_line = line_reg >= LINE_W'(VISIBLE_LINES);

    always_comb begin
        cnt             = lcc_reg + CNT_W'(elapsed_cycles);
        cnt_ext         = CMP_W'(cnt);
        mode_next       = mode_reg;
        prev_mode_next  = prev_mode_reg;
        line_done_next  = line_done_reg;
        frame_done_next = frame_done_reg;
        coin_next       = coin_reg;
        stat            = 1'b0;
        vbl             = 1'b0;
        render          = 1'b0;
        render_num      = '0;
        lcc_next        = cnt;
        line_adv        = line_reg;

        if (vblank_line) begin
            stat           = cfg.vblank_stat_irq_enable && (prev_mode_reg != MODE_VBLANK);
            mode_next      = MODE_VBLANK;
            prev_mode_next = MODE_VBLANK;
        end else if (cnt_ext < CMP_W'(OAM_END)) begin
            stat           = cfg.oam_irq_enable && (prev_mode_reg != MODE_OAM);
            mode_next      = MODE_OAM;
            prev_mode_next = MODE_OAM;
        end else if (cnt_ext < CMP_W'(DRAW_END)) begin
            mode_next      = MODE_DRAW;
        end else if (cnt <= CNT_W'(LINE_CYCLES)) begin
            stat           = cfg.hblank_irq_enable && (prev_mode_reg != MODE_HBLANK);
            mode_next      = MODE_HBLANK;
            prev_mode_next = MODE_HBLANK;
        end

        if (cnt_ext >= CMP_W'(DRAW_END) && line_reg <= LINE_W'(VISIBLE_LINES)
                && !line_done_reg) begin
            render         = 1'b1;
            render_num     = line_reg;
            line_done_next = 1'b1;
        end

        if (!frame_done_reg && line_reg == LINE_W'(VISIBLE_LINES) && cfg.display_enable) begin
            vbl             = 1'b1;
            frame_done_next = 1'b1;
        end

        if (cnt > CNT_W'(LINE_CYCLES)) begin
            lcc_next       = cnt - CNT_W'(LINE_CYCLES);
            line_adv       = line_reg + LINE_W'(1);
            line_done_next = 1'b0;
        end

        if (line_adv == cfg.line_compare_value) begin
            if (cfg.coincidence_irq_enable && !coin_reg) begin
                stat      = 1'b1;
                coin_next = 1'b1;
            end
        end else begin
            coin_next = 1'b0;
        end

        line_next = line_adv;
        if (line_adv > LINE_W'(LAST_LINE)) begin
            line_next       = '0;
            frame_done_next = 1'b0;
        end

        result.lcd_mode           = mode_next;
        result.current_line       = line_next;
        result.coincidence_flag   = coin_next;
        result.stat_irq_request   = stat;
        result.vblank_irq_request = vbl;
        result.render_line_pulse  = render;
        result.render_line_number = render_num;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcc_reg        <= '0;
            line_reg       <= '0;
            mode_reg       <= MODE_HBLANK;
            prev_mode_reg  <= MODE_HBLANK;
            line_done_reg  <= 1'b0;
            frame_done_reg <= 1'b0;
            coin_reg       <= 1'b0;
        end else if (advance) begin
            lcc_reg        <= lcc_next;
            line_reg       <= line_next;
            mode_reg       <= mode_next;
            prev_mode_reg  <= prev_mode_next;
            line_done_reg  <= line_done_next;
            frame_done_reg <= frame_done_next;
            coin_reg       <= coin_next;
        end
    end

    `ASSERT_CLK(a_line_in_range, line_reg <= LINE_W'(LAST_LINE), "line counter past last line")
    `ASSERT_CLK(a_cycles_in_range, lcc_reg <= CNT_W'(LINE_CYCLES), "cycle count past line end")
    `ASSERT_CLK(a_vblank_mode, advance && vblank_line |=> mode_reg == MODE_VBLANK, "not vblank")

endmodule

@@ rtl/lcd_mode_and_line_timing.sv @@
// Top level of the LCD mode and line timing block.
//
// Each request carries the clock cycles elapsed since the previous one; the
// block advances its line timing and returns one result per request with the
// LCD mode, the current line, the coincidence flag and the interrupt and
// render pulses. One request is taken every clock unless the input side is
// stalled: the request passes an input register, a single pass of
// compare-and-add logic updates the timing state, and the result lands in
// an output register. Back-pressure on the result side stalls the input
// side only when both registers are full. Configuration writes are taken
// every cycle and act on the next request processed.
module lcd_mode_and_line_timing #(
    parameter int LINE_CYCLES   = 456,
    parameter int VISIBLE_LINES = 144,
    parameter int LAST_LINE     = 154
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // elapsed_cycles[5:0]
    input  logic [lmlt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // lcd_mode[1:0], current_line[9:2], coincidence_flag[10],
    // stat_irq_request[11], vblank_irq_request[12], render_line_pulse[13],
    // render_line_number[21:14]
    output logic [lmlt_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lmlt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmlt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lmlt_pkg::*;

    cfg_t                 cfg;
    result_t              result;
    logic                 advance;
    logic                 in_valid_reg, in_valid_next;
    logic [ELAPSED_W-1:0] in_data_reg;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_data_reg;

    lmlt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lmlt_step #(
        .LINE_CYCLES   (LINE_CYCLES),
        .VISIBLE_LINES (VISIBLE_LINES),
        .LAST_LINE     (LAST_LINE)
    ) u_step (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .advance        (advance),
        .elapsed_cycles (in_data_reg),
        .result         (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[ELAPSED_W-1:0];
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_data_reg.render_line_number,
                       out_data_reg.render_line_pulse,
                       out_data_reg.vblank_irq_request,
                       out_data_reg.stat_irq_request,
                       out_data_reg.coincidence_flag,
                       out_data_reg.current_line,
                       out_data_reg.lcd_mode};

endmodule

@@ dv/lcd_mode_and_line_timing_tb.sv @@
// Self-checking testbench for the LCD mode and line timing block.
module lcd_mode_and_line_timing_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lmlt_pkg::*;

    localparam int LINE_CYCLES    = 456;
    localparam int VISIBLE_LINES  = 144;
    localparam int LAST_LINE      = 154;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int ITEMS_PER_PHASE = 200;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  idle_on   = 1'b0;
    logic                  hold_off  = 1'b0;

    logic [ELAPSED_W-1:0]  pending_elapsed[$];
    result_t               expected_timing[$];
    int                    results_due;
    int                    requests_taken;
    int                    results_seen;
    int                    mismatches;
    int                    send_gap;
    int                    stall_left;
    int                    quiet_cycles;

    cfg_t                  cfg_q;
    logic [9:0]            cyc_cnt;
    logic [LINE_W-1:0]     line_q;
    lcd_mode_t             mode_q;
    lcd_mode_t             prev_irq_mode;
    logic                  line_drawn;
    logic                  frame_flagged;
    logic                  coinc_q;

    result_t               want_r;

    lcd_mode_and_line_timing #(
        .LINE_CYCLES   (LINE_CYCLES),
        .VISIBLE_LINES (VISIBLE_LINES),
        .LAST_LINE     (LAST_LINE)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic reset_timing();
        cfg_q                        = '0;
        cfg_q.display_enable         = 1'b1;
        cyc_cnt                      = '0;
        line_q                       = '0;
        mode_q                       = MODE_HBLANK;
        prev_irq_mode                = MODE_HBLANK;
        line_drawn                   = 1'b0;
        frame_flagged                = 1'b0;
        coinc_q                      = 1'b0;
    endtask

    task automatic advance_timing(input logic [ELAPSED_W-1:0] elapsed);
        int unsigned cnt;
        result_t     r;
        r   = '0;
        cnt = int'(cyc_cnt) + int'(elapsed);
        if (line_q >= VISIBLE_LINES) begin
            if (cfg_q.vblank_stat_irq_enable && prev_irq_mode != MODE_VBLANK)
                r.stat_irq_request = 1'b1;
            mode_q        = MODE_VBLANK;
            prev_irq_mode = MODE_VBLANK;
        end else if (cnt < OAM_END) begin
            if (cfg_q.oam_irq_enable && prev_irq_mode != MODE_OAM)
                r.stat_irq_request = 1'b1;
            mode_q        = MODE_OAM;
            prev_irq_mode = MODE_OAM;
        end else if (cnt < DRAW_END) begin
            mode_q = MODE_DRAW;
        end else if (cnt <= LINE_CYCLES) begin
            if (cfg_q.hblank_irq_enable && prev_irq_mode != MODE_HBLANK)
                r.stat_irq_request = 1'b1;
            mode_q        = MODE_HBLANK;
            prev_irq_mode = MODE_HBLANK;
        end
        if (cnt >= DRAW_END && line_q <= VISIBLE_LINES && !line_drawn) begin
            r.render_line_pulse  = 1'b1;
            r.render_line_number = line_q;
            line_drawn           = 1'b1;
        end
        if (!frame_flagged && line_q == VISIBLE_LINES && cfg_q.display_enable) begin
            r.vblank_irq_request = 1'b1;
            frame_flagged        = 1'b1;
        end
        if (cnt > LINE_CYCLES) begin
            cnt           = cnt - LINE_CYCLES;
            line_q        = line_q + 8'd1;
            line_drawn    = 1'b0;
        end
        cyc_cnt = cnt[9:0];
        if (line_q == cfg_q.line_compare_value) begin
            if (cfg_q.coincidence_irq_enable && !coinc_q) begin
                r.stat_irq_request = 1'b1;
                coinc_q            = 1'b1;
            end
        end else begin
            coinc_q = 1'b0;
        end
        if (line_q > LAST_LINE) begin
            line_q        = '0;
            frame_flagged = 1'b0;
        end
        r.lcd_mode         = mode_q;
        r.current_line     = line_q;
        r.coincidence_flag = coinc_q;
        expected_timing.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR: result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_timing(s_tdata[ELAPSED_W-1:0]);
                requests_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_elapsed.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(pending_elapsed.pop_front());
                    if (idle_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 8);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_timing.size() == 0) begin
                    report_mismatch("result with no request pending");
                end else begin
                    want_r = expected_timing.pop_front();
                    check_field("lcd_mode", m_tdata[1:0], want_r.lcd_mode);
                    check_field("current_line", m_tdata[9:2], want_r.current_line);
                    check_field("coincidence_flag", m_tdata[10], want_r.coincidence_flag);
                    check_field("stat_irq_request", m_tdata[11], want_r.stat_irq_request);
                    check_field("vblank_irq_request", m_tdata[12], want_r.vblank_irq_request);
                    check_field("render_line_pulse", m_tdata[13], want_r.render_line_pulse);
                    check_field("render_line_number", m_tdata[21:14],
                                want_r.render_line_number);
                end
                results_seen++;
                results_due--;
            end
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 6) == 0)
                    stall_left = $urandom_range(1, 8);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("lcd_mode_and_line_timing: mismatch");
            $finish;
        end
    end

    // hold off the receiver long enough to fill the block and stall its input
    initial begin
        wait (requests_taken >= 150);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    task automatic drain();
        while (results_due > 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (cfg_reg_t'(idx))
            REG_DISPLAY_ENABLE:  cfg_q.display_enable         = val[0];
            REG_LINE_COMPARE:    cfg_q.line_compare_value     = val;
            REG_HBLANK_IRQ_EN:   cfg_q.hblank_irq_enable      = val[0];
            REG_VBLANK_IRQ_EN:   cfg_q.vblank_stat_irq_enable = val[0];
            REG_OAM_IRQ_EN:      cfg_q.oam_irq_enable         = val[0];
            REG_COINCIDENCE_IRQ: cfg_q.coincidence_irq_enable = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] flag_word(input logic flag);
        return {CFG_DATA_W'($urandom_range(0, 127)) << 1} | CFG_DATA_W'(flag);
    endfunction

    task automatic set_config(input logic en, input logic [LINE_W-1:0] cmp, input logic hb,
                              input logic vb, input logic oam, input logic co);
        drain();
        repeat (4) @(posedge aclk);
        write_reg(REG_DISPLAY_ENABLE, flag_word(en));
        write_reg(REG_LINE_COMPARE, cmp);
        write_reg(REG_HBLANK_IRQ_EN, flag_word(hb));
        write_reg(REG_VBLANK_IRQ_EN, flag_word(vb));
        write_reg(REG_OAM_IRQ_EN, flag_word(oam));
        write_reg(REG_COINCIDENCE_IRQ, flag_word(co));
    endtask

    task automatic push_elapsed(input logic [ELAPSED_W-1:0] v);
        pending_elapsed.push_back(v);
        results_due++;
    endtask

    // mostly long steps so the run crosses many lines, with short ones mixed in
    task automatic push_random(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                push_elapsed(ELAPSED_W'($urandom_range(0, 63)));
            else
                push_elapsed(ELAPSED_W'($urandom_range(48, 63)));
        end
    endtask

    task automatic run_phase(input logic en, input logic [LINE_W-1:0] cmp, input logic hb,
                             input logic vb, input logic oam, input logic co);
        set_config(en, cmp, hb, vb, oam, co);
        push_random(ITEMS_PER_PHASE / 2);
        drain();
        push_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
    endtask

    logic [ELAPSED_W-1:0] directed_steps[] = '{
        6'd0, 6'd63, 6'd17, 6'd1, 6'h2a, 6'h2a, 6'h15, 6'd63, 6'd3, 6'd1,
        6'd63, 6'd63, 6'd63, 6'd14, 6'd1, 6'd63, 6'd17, 6'd0, 6'd63
    };

    initial begin
        reset_timing();
        results_due    = 0;
        requests_taken = 0;
        results_seen   = 0;
        mismatches     = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on <= 1'b1;

        set_config(1'b1, 8'd1, 1'b1, 1'b1, 1'b1, 1'b1);
        for (int i = int'(REG_COINCIDENCE_IRQ) + 1; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom_range(0, 255)));
        foreach (directed_steps[i])
            push_elapsed(directed_steps[i]);

        run_phase(1'b1, 8'd144, 1'b1, 1'b1, 1'b0, 1'b1);
        run_phase(1'b0, 8'd255, 1'b0, 1'b1, 1'b1, 1'b0);
        run_phase(1'b1, LINE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
        set_config(1'b1, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        idle_on <= 1'b0;
        push_random(ITEMS_PER_PHASE);

        drain();
        repeat (10) @(posedge aclk);
        if (expected_timing.size() != 0)
            report_mismatch("expected results left over");
        if (mismatches == 0)
            $display("lcd_mode_and_line_timing: match");
        else
            $display("lcd_mode_and_line_timing: mismatch");
        $finish;
    end

endmodule

@@ lcd_mode_and_line_timing.f @@
+incdir+rtl
rtl/lmlt_pkg.sv
rtl/lmlt_cfg_regs.sv
rtl/lmlt_step.sv
rtl/lcd_mode_and_line_timing.sv
dv/lcd_mode_and_line_timing_tb.sv
